/* rtl/pressure_temp_compensation_top_assert.svh */
// Assertion macros for the barometric compensation block.
`ifndef PRESSURE_TEMP_COMPENSATION_TOP_ASSERT_SVH
`define PRESSURE_TEMP_COMPENSATION_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PTC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PTC_ASSERT(lbl, prop, msg)
`define PTC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/ptc_pkg.sv */
// Shared constants, types and helpers of the compensation block.
`default_nettype none
package ptc_pkg;

    localparam int PressureFracBits = 8;
    localparam int RAW_W     = 20;
    localparam int COEF_W    = 48;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 64;
    localparam int MUL_W     = 64;
    localparam int PROD_W    = 128;
    localparam int CNT_W     = 7;
    localparam int NUM_W     = 113;
    localparam int DEN_W     = 80;
    localparam int QUOT_W    = 49;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_TEMP    = 2'd0;
    localparam logic [1:0] REG_PRESS_A = 2'd1;
    localparam logic [1:0] REG_PRESS_B = 2'd2;
    localparam logic [1:0] REG_PRESS_C = 2'd3;

    typedef struct packed {
        logic               start;
        logic [MUL_W-1:0]   a;
        logic [MUL_W-1:0]   b;
        logic [CNT_W-1:0]   nbits;
        logic               neg;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic               busy;
        logic [PROD_W-1:0]  prod;
    } mul_rsp_t;

    typedef struct packed {
        logic               start;
        logic [NUM_W-1:0]   num;
        logic [DEN_W-1:0]   den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic               busy;
        logic [QUOT_W-1:0]  quot;
        logic               ovf;
    } div_rsp_t;

    // Magnitude of a 16-bit two's complement word.
    function automatic logic [15:0] mag16(input logic [15:0] x);
        mag16 = x[15] ? (~x + 16'd1) : x;
    endfunction

    // Magnitude of a 64-bit two's complement word.
    function automatic logic [63:0] mag64(input logic [63:0] x);
        mag64 = x[63] ? (~x + 64'd1) : x;
    endfunction

endpackage
`default_nettype wire

/* rtl/ptc_mul.sv */
// Bit-serial shift-add multiplier with sign applied to the product.
`default_nettype none
module ptc_mul (
    input  logic                clk,
    input  logic                rst_n,
    input  ptc_pkg::mul_req_t   req,
    output ptc_pkg::mul_rsp_t   rsp
);
    import ptc_pkg::*;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               neg_reg, neg_next;
    logic [PROD_W-1:0]  acc_reg, acc_next;
    logic [PROD_W-1:0]  ash_reg, ash_next;
    logic [MUL_W-1:0]   bsh_reg, bsh_next;

    // One multiplier bit is consumed per cycle, least significant first.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        ash_next  = ash_reg;
        bsh_next  = bsh_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.nbits;
            neg_next  = req.neg;
            acc_next  = '0;
            ash_next  = {{(PROD_W-MUL_W){1'b0}}, req.a};
            bsh_next  = req.b;
        end
        else if (busy_reg)
        begin
            if (bsh_reg[0])
            begin
                acc_next = acc_reg + ash_reg;
            end
            ash_next = ash_reg << 1;
            bsh_next = bsh_reg >> 1;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        ash_reg <= ash_next;
        bsh_reg <= bsh_next;
    end

    assign rsp.done = done_reg;
    assign rsp.busy = busy_reg;
    assign rsp.prod = neg_reg ? (~acc_reg + PROD_W'(1)) : acc_reg;

endmodule
`default_nettype wire

/* rtl/ptc_div.sv */
// Restoring divider, one quotient bit per cycle, with quotient overflow flag.
`default_nettype none
module ptc_div (
    input  logic                clk,
    input  logic                rst_n,
    input  ptc_pkg::div_req_t   req,
    output ptc_pkg::div_rsp_t   rsp
);
    import ptc_pkg::*;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [NUM_W-1:0]   nsh_reg, nsh_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [DEN_W-1:0]   rem_reg, rem_next;
    logic [QUOT_W-1:0]  quot_reg, quot_next;
    logic               ovf_reg, ovf_next;
    logic [DEN_W:0]     rem_shift;
    logic [DEN_W:0]     rem_diff;
    logic               fits;

    // Trial subtraction of the divisor from the shifted remainder.
    assign rem_shift = {rem_reg, nsh_reg[NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign fits      = (rem_shift >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        nsh_next  = nsh_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        ovf_next  = ovf_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            nsh_next  = req.num;
            den_next  = req.den;
            rem_next  = '0;
            quot_next = '0;
            ovf_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            quot_next = {quot_reg[QUOT_W-2:0], fits};
            ovf_next  = ovf_reg | quot_reg[QUOT_W-1];
            nsh_next  = nsh_reg << 1;
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nsh_reg  <= nsh_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        ovf_reg  <= ovf_next;
    end

    assign rsp.done = done_reg;
    assign rsp.busy = busy_reg;
    assign rsp.quot = quot_reg;
    assign rsp.ovf  = ovf_reg;

endmodule
`default_nettype wire

/* rtl/pressure_temp_compensation_top.sv */
// Top level of the barometric temperature and pressure compensation block.
// One word is processed at a time. A temperature word takes three serial
// products plus a finish state, and a pressure word ten serial products in
// the shared shift-add multiplier plus one division in the restoring
// divider; these two serial units set the rate. A new word is taken as soon
// as the previous result has moved into the output register, even while
// that result is still stalled. Calibration registers sit at byte addresses
// 0, 8, 16, 24 and may only be written while the block is idle.
`default_nettype none
`include "pressure_temp_compensation_top_assert.svh"
module pressure_temp_compensation_top #(
    parameter int PRESSURE_FRAC_BITS = ptc_pkg::PressureFracBits
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ptc_pkg::APB_AW-1:0]    paddr,
    input  logic [ptc_pkg::APB_DW-1:0]    pwdata,
    output logic [ptc_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic [ptc_pkg::RAW_W-1:0]     raw_adc,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          kind,
    output logic signed [31:0]            temp_centi,
    output logic [31:0]                   press_q24_8
);
    import ptc_pkg::*;

    localparam int SH = 59 - PRESSURE_FRAC_BITS;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_T_MUL1 = 5'd1;
    localparam logic [4:0] S_T_MUL2 = 5'd2;
    localparam logic [4:0] S_T_MUL3 = 5'd3;
    localparam logic [4:0] S_T_FIN  = 5'd4;
    localparam logic [4:0] S_P_DSQ  = 5'd5;
    localparam logic [4:0] S_P_M3   = 5'd6;
    localparam logic [4:0] S_P_M2   = 5'd7;
    localparam logic [4:0] S_P_M6   = 5'd8;
    localparam logic [4:0] S_P_M5   = 5'd9;
    localparam logic [4:0] S_P_NUM  = 5'd10;
    localparam logic [4:0] S_P_DEN  = 5'd11;
    localparam logic [4:0] S_P_DIV  = 5'd12;
    localparam logic [4:0] S_P_M9A  = 5'd13;
    localparam logic [4:0] S_P_M9B  = 5'd14;
    localparam logic [4:0] S_P_M8   = 5'd15;
    localparam logic [4:0] S_P_FIN  = 5'd16;
    localparam logic [4:0] S_OUT    = 5'd17;

    // Control registers.
    logic [4:0]         state_reg, state_next;
    logic               issued_reg, issued_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        fine_reg, fine_next;
    logic [COEF_W-1:0]  tc_reg, pa_reg, pb_reg, pc_reg;

    // Payload registers.
    logic               cmd_reg, cmd_next;
    logic [RAW_W-1:0]   raw_reg, raw_next;
    logic [31:0]        v1_reg, v1_next;
    logic [19:0]        tsq_reg, tsq_next;
    logic [63:0]        d2_reg, d2_next;
    logic [63:0]        n1_reg, n1_next;
    logic [63:0]        n2_reg, n2_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [QUOT_W-1:0]  qm_reg, qm_next;
    logic               qneg_reg, qneg_next;
    logic [63:0]        m9_reg, m9_next;
    logic [PROD_W-1:0]  s_reg, s_next;
    logic [31:0]        rtemp_reg, rtemp_next;
    logic [31:0]        rpress_reg, rpress_next;
    logic               kind_reg, kind_next;
    logic [31:0]        otemp_reg, otemp_next;
    logic [31:0]        opress_reg, opress_next;

    mul_req_t           mul_req;
    mul_rsp_t           mul_rsp;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    // Calibration words.
    logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = tc_reg[15:0];
    assign t2 = tc_reg[31:16];
    assign t3 = tc_reg[47:32];
    assign p1 = pa_reg[15:0];
    assign p2 = pa_reg[31:16];
    assign p3 = pa_reg[47:32];
    assign p4 = pb_reg[15:0];
    assign p5 = pb_reg[31:16];
    assign p6 = pb_reg[47:32];
    assign p7 = pc_reg[15:0];
    assign p8 = pc_reg[31:16];
    assign p9 = pc_reg[47:32];

    // Temperature operands.
    logic [18:0] at, bt, at_mag, bt_mag;
    logic [19:0] tsq_mag;
    assign at      = {2'b00, raw_reg[19:3]} - {2'b00, t1, 1'b0};
    assign bt      = {3'b000, raw_reg[19:4]} - {3'b000, t1};
    assign at_mag  = at[18] ? (~at + 19'd1) : at;
    assign bt_mag  = bt[18] ? (~bt + 19'd1) : bt;
    assign tsq_mag = tsq_reg[19] ? (~tsq_reg + 20'd1) : tsq_reg;

    // Pressure operands: offset of the fine temperature.
    logic [33:0] dv, d_mag;
    assign dv    = {{2{fine_reg[31]}}, fine_reg} - 34'd128000;
    assign d_mag = dv[33] ? (~dv + 34'd1) : dv;

    // Starting value of the second numerator from the raw reading and P4.
    logic [20:0] raw_span;
    logic [63:0] n2_init;
    assign raw_span = {1'b1, {RAW_W{1'b0}}} - {1'b0, raw_adc};
    assign n2_init  = ({43'd0, raw_span} << 31) - ({{48{p4[15]}}, p4} << 35);

    // Clamped quotient and the first two terms of the final sum.
    logic [QUOT_W-1:0]  q_clamp;
    logic [PROD_W-1:0]  q_shift, s_init;
    assign q_clamp = (div_rsp.ovf || (div_rsp.quot > {1'b1, {(QUOT_W-1){1'b0}}}))
                   ? {1'b1, {(QUOT_W-1){1'b0}}} : div_rsp.quot;
    assign q_shift = {{(PROD_W-QUOT_W){1'b0}}, q_clamp} << 47;
    assign s_init  = (qneg_reg ? (~q_shift + PROD_W'(1)) : q_shift)
                   + ({{(PROD_W-16){p7[15]}}, p7} << 55);

    // Final temperature scaling.
    logic [31:0] t_scaled;
    assign t_scaled = {fine_reg[29:0], 2'b00} + fine_reg + 32'd128;

    // Operand selection for the shared multiplier.
    logic mul_state;
    always_comb
    begin
        mul_state     = 1'b1;
        mul_req.a     = '0;
        mul_req.b     = '0;
        mul_req.nbits = 7'd16;
        mul_req.neg   = 1'b0;
        case (state_reg)
            S_T_MUL1:
            begin
                mul_req.a   = 64'(at_mag);
                mul_req.b   = 64'(mag16(t2));
                mul_req.neg = at[18] ^ t2[15];
            end
            S_T_MUL2:
            begin
                mul_req.a     = 64'(bt_mag);
                mul_req.b     = 64'(bt_mag);
                mul_req.nbits = 7'd17;
            end
            S_T_MUL3:
            begin
                mul_req.a   = 64'(tsq_mag);
                mul_req.b   = 64'(mag16(t3));
                mul_req.neg = tsq_reg[19] ^ t3[15];
            end
            S_P_DSQ:
            begin
                mul_req.a     = 64'(d_mag);
                mul_req.b     = 64'(d_mag);
                mul_req.nbits = 7'd34;
            end
            S_P_M3:
            begin
                mul_req.a   = mag64(d2_reg);
                mul_req.b   = 64'(mag16(p3));
                mul_req.neg = d2_reg[63] ^ p3[15];
            end
            S_P_M2:
            begin
                mul_req.a   = 64'(d_mag);
                mul_req.b   = 64'(mag16(p2));
                mul_req.neg = dv[33] ^ p2[15];
            end
            S_P_M6:
            begin
                mul_req.a   = mag64(d2_reg);
                mul_req.b   = 64'(mag16(p6));
                mul_req.neg = d2_reg[63] ^ p6[15];
            end
            S_P_M5:
            begin
                mul_req.a   = 64'(d_mag);
                mul_req.b   = 64'(mag16(p5));
                mul_req.neg = dv[33] ^ p5[15];
            end
            S_P_NUM:
            begin
                mul_req.a     = mag64(n2_reg);
                mul_req.b     = 64'd6250;
                mul_req.nbits = 7'd13;
            end
            S_P_DEN:
            begin
                mul_req.a = mag64(n1_reg);
                mul_req.b = 64'(p1);
            end
            S_P_M9A:
            begin
                mul_req.a = 64'(qm_reg);
                mul_req.b = 64'(mag16(p9));
            end
            S_P_M9B:
            begin
                mul_req.a     = m9_reg;
                mul_req.b     = 64'(qm_reg);
                mul_req.nbits = 7'(QUOT_W);
                mul_req.neg   = p9[15];
            end
            S_P_M8:
            begin
                mul_req.a   = 64'(qm_reg);
                mul_req.b   = 64'(mag16(p8));
                mul_req.neg = p8[15] ^ qneg_reg;
            end
            default:
            begin
                mul_state = 1'b0;
            end
        endcase
        mul_req.start = mul_state && !issued_reg;
    end

    assign div_req.start = (state_reg == S_P_DIV) && !issued_reg;
    assign div_req.num   = num_reg;
    assign div_req.den   = den_reg;

    ptc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    ptc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Sequencer: issue one serial operation, then capture it when done.
    logic unit_state, unit_done, out_load;
    assign unit_state = mul_state || (state_reg == S_P_DIV);
    assign unit_done  = mul_state ? mul_rsp.done : div_rsp.done;
    assign out_load   = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        issued_next    = issued_reg;
        fine_next      = fine_reg;
        cmd_next       = cmd_reg;
        raw_next       = raw_reg;
        v1_next        = v1_reg;
        tsq_next       = tsq_reg;
        d2_next        = d2_reg;
        n1_next        = n1_reg;
        n2_next        = n2_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        qm_next        = qm_reg;
        qneg_next      = qneg_reg;
        m9_next        = m9_reg;
        s_next         = s_reg;
        rtemp_next     = rtemp_reg;
        rpress_next    = rpress_reg;
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        otemp_next     = otemp_reg;
        opress_next    = opress_reg;

        if (unit_state)
        begin
            if (!issued_reg)
            begin
                issued_next = 1'b1;
            end
            else if (unit_done)
            begin
                issued_next = 1'b0;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd;
                    raw_next   = raw_adc;
                    n1_next    = 64'd1 << 55;
                    n2_next    = n2_init;
                    state_next = cmd ? S_P_DSQ : S_T_MUL1;
                end
            end
            S_T_MUL1:
            begin
                if (issued_reg && unit_done)
                begin
                    v1_next    = {{11{mul_rsp.prod[31]}}, mul_rsp.prod[31:11]};
                    state_next = S_T_MUL2;
                end
            end
            S_T_MUL2:
            begin
                if (issued_reg && unit_done)
                begin
                    tsq_next   = mul_rsp.prod[31:12];
                    state_next = S_T_MUL3;
                end
            end
            S_T_MUL3:
            begin
                if (issued_reg && unit_done)
                begin
                    fine_next  = v1_reg + {{14{mul_rsp.prod[31]}}, mul_rsp.prod[31:14]};
                    state_next = S_T_FIN;
                end
            end
            S_T_FIN:
            begin
                rtemp_next  = {{8{t_scaled[31]}}, t_scaled[31:8]};
                rpress_next = '0;
                state_next  = S_OUT;
            end
            S_P_DSQ:
            begin
                if (issued_reg && unit_done)
                begin
                    d2_next    = mul_rsp.prod[63:0];
                    state_next = S_P_M3;
                end
            end
            S_P_M3:
            begin
                if (issued_reg && unit_done)
                begin
                    n1_next    = n1_reg + mul_rsp.prod[63:0];
                    state_next = S_P_M2;
                end
            end
            S_P_M2:
            begin
                if (issued_reg && unit_done)
                begin
                    n1_next    = n1_reg + {mul_rsp.prod[43:0], 20'd0};
                    state_next = S_P_M6;
                end
            end
            S_P_M6:
            begin
                if (issued_reg && unit_done)
                begin
                    n2_next    = n2_reg - mul_rsp.prod[63:0];
                    state_next = S_P_M5;
                end
            end
            S_P_M5:
            begin
                if (issued_reg && unit_done)
                begin
                    n2_next    = n2_reg - {mul_rsp.prod[46:0], 17'd0};
                    state_next = S_P_NUM;
                end
            end
            S_P_NUM:
            begin
                if (issued_reg && unit_done)
                begin
                    num_next   = {mul_rsp.prod[76:0], 36'd0};
                    qneg_next  = n2_reg[63] ^ n1_reg[63];
                    state_next = S_P_DEN;
                end
            end
            S_P_DEN:
            begin
                if (issued_reg && unit_done)
                begin
                    den_next = mul_rsp.prod[DEN_W-1:0];
                    // A zero divisor gives zero pressure.
                    if (mul_rsp.prod[DEN_W-1:0] == '0)
                    begin
                        rtemp_next  = '0;
                        rpress_next = '0;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        state_next = S_P_DIV;
                    end
                end
            end
            S_P_DIV:
            begin
                if (issued_reg && unit_done)
                begin
                    qm_next    = q_clamp;
                    s_next     = s_init;
                    state_next = S_P_M9A;
                end
            end
            S_P_M9A:
            begin
                if (issued_reg && unit_done)
                begin
                    m9_next    = mul_rsp.prod[63:0];
                    state_next = S_P_M9B;
                end
            end
            S_P_M9B:
            begin
                if (issued_reg && unit_done)
                begin
                    s_next     = s_reg + mul_rsp.prod;
                    state_next = S_P_M8;
                end
            end
            S_P_M8:
            begin
                if (issued_reg && unit_done)
                begin
                    s_next     = s_reg + (mul_rsp.prod << 28);
                    state_next = S_P_FIN;
                end
            end
            S_P_FIN:
            begin
                // Negative sums clamp to zero, large ones to all ones.
                rtemp_next = '0;
                if (s_reg[PROD_W-1])
                begin
                    rpress_next = '0;
                end
                else if (|s_reg[PROD_W-1:SH+32])
                begin
                    rpress_next = '1;
                end
                else
                begin
                    rpress_next = s_reg[SH+31:SH];
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = cmd_reg;
                    otemp_next     = rtemp_reg;
                    opress_next    = rpress_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and calibration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            fine_reg      <= '0;
            tc_reg        <= '0;
            pa_reg        <= '0;
            pb_reg        <= '0;
            pc_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
            fine_reg      <= fine_next;
            if (psel && penable && pwrite)
            begin
                case (paddr[4:3])
                    REG_TEMP:    tc_reg <= pwdata[COEF_W-1:0];
                    REG_PRESS_A: pa_reg <= pwdata[COEF_W-1:0];
                    REG_PRESS_B: pb_reg <= pwdata[COEF_W-1:0];
                    REG_PRESS_C: pc_reg <= pwdata[COEF_W-1:0];
                    default:     tc_reg <= tc_reg;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        raw_reg    <= raw_next;
        v1_reg     <= v1_next;
        tsq_reg    <= tsq_next;
        d2_reg     <= d2_next;
        n1_reg     <= n1_next;
        n2_reg     <= n2_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        qm_reg     <= qm_next;
        qneg_reg   <= qneg_next;
        m9_reg     <= m9_next;
        s_reg      <= s_next;
        rtemp_reg  <= rtemp_next;
        rpress_reg <= rpress_next;
        kind_reg   <= kind_next;
        otemp_reg  <= otemp_next;
        opress_reg <= opress_next;
    end

    // Register read-back.
    always_comb
    begin
        case (paddr[4:3])
            REG_TEMP:    prdata = {{(APB_DW-COEF_W){1'b0}}, tc_reg};
            REG_PRESS_A: prdata = {{(APB_DW-COEF_W){1'b0}}, pa_reg};
            REG_PRESS_B: prdata = {{(APB_DW-COEF_W){1'b0}}, pb_reg};
            REG_PRESS_C: prdata = {{(APB_DW-COEF_W){1'b0}}, pc_reg};
            default:     prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign temp_centi  = otemp_reg;
    assign press_q24_8 = opress_reg;

    // Checks on the sequencer and the serial units.
    `PTC_ASSERT(a_mul_start_idle, mul_req.start |-> !mul_rsp.busy, "multiplier restarted while busy")
    `PTC_ASSERT(a_div_start_idle, div_req.start |-> !div_rsp.busy, "divider restarted while busy")
    `PTC_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall, "word accepted but block idle")
    `PTC_ASSERT(a_out_from_seq, $rose(out_valid_reg) |-> $past(state_reg) == S_OUT, "result without finish")

endmodule
`default_nettype wire
